FILE: sv/htw_pkg.sv
// htw_pkg: shared types, codes and fixed widths of the timer wheel
// used by the channel interfaces, the controller and the datapath
package htw_pkg;

  localparam int CMD_W     = 2;
  localparam int HANDLE_W  = 32;
  localparam int SESSION_W = 32;
  localparam int DELAY_W   = 31;
  localparam int KIND_W    = 3;
  localparam int TICK_W    = 32;
  localparam int LINK_W    = 7;
  localparam logic [LINK_W-1:0] EMPTY_MARK = 7'd127;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ONESHOT   = 3'd0,
    KIND_REPEAT    = 3'd1,
    KIND_ADDED     = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_IMMEDIATE = 3'd4,
    KIND_IGNORED   = 3'd5,
    KIND_CANCEL    = 3'd6
  } kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ADD_WR,
    ST_PLACE,
    ST_PUSH_RD,
    ST_PUSH_WR,
    ST_ADD_ACK,
    ST_TAKE_RD,
    ST_TAKE_WR,
    ST_FIRE_RD,
    ST_FIRE_USE,
    ST_CASC_RD,
    ST_CASC_USE,
    ST_ADVANCE,
    ST_ADV_CHK,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    MODE_ADD,
    MODE_FIRE,
    MODE_CASC
  } mode_t;

  typedef enum logic [1:0] {
    BSEL_FIRE,
    BSEL_CASC,
    BSEL_PLACE
  } bsel_t;

  typedef enum logic [1:0] {
    SRC_ECHO,
    SRC_FIRE,
    SRC_CANCEL
  } emsrc_t;

  typedef struct packed {
    logic [TICK_W-1:0]           expire;
    logic [DELAY_W-1:0]          period;
    logic [HANDLE_W-1:0]         dest;
    logic signed [SESSION_W-1:0] sess;
  } rec_t;

  typedef struct packed {
    logic   latch;
    logic   clr_step;
    logic   scan_start;
    logic   scan_step;
    logic   scan_unreg;
    logic   cancel_hit;
    logic   add_write;
    logic   b_load;
    bsel_t  b_sel;
    logic   push_rd;
    logic   push_wr;
    logic   take_rd;
    logic   take_wr;
    logic   walk_rd;
    logic   fire_use;
    logic   casc_use;
    logic   adv;
    logic   emit;
    emsrc_t emit_src;
    kind_t  kind;
    logic   flush;
  } ctl_t;

  typedef struct packed {
    logic             clr_done;
    logic [CMD_W-1:0] cmd;
    logic             delay_zero;
    logic             rep;
    logic             pool_empty;
    logic             scan_match;
    logic             scan_end;
    logic             cur_empty;
    logic             cur_live;
    logic             rearm;
    logic             casc_hit;
    logic             emit_ok;
    logic             pend_valid;
  } sts_t;

endpackage

FILE: sv/htw_req_if.sv
// htw_req_if: command channel of the timer wheel
// depends on htw_pkg for field widths
interface htw_req_if;
  import htw_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [CMD_W-1:0]            cmd;
  logic [HANDLE_W-1:0]         handle;
  logic signed [SESSION_W-1:0] session;
  logic [DELAY_W-1:0]          delay;
  logic                        repeat_req;

  modport source (output valid, cmd, handle, session, delay, repeat_req, input ready);
  modport sink (input valid, cmd, handle, session, delay, repeat_req, output ready);
endinterface

FILE: sv/htw_rsp_if.sv
// htw_rsp_if: result channel of the timer wheel
// depends on htw_pkg for field widths
interface htw_rsp_if;
  import htw_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  logic [HANDLE_W-1:0]         handle_out;
  logic signed [SESSION_W-1:0] session_out;
  logic                        last;

  modport source (output valid, kind, handle_out, session_out, last, input ready);
  modport sink (input valid, kind, handle_out, session_out, last, output ready);
endinterface

FILE: sv/htw_ctrl.sv
// htw_ctrl: sequencer for add, cancel and tick commands
// depends on htw_pkg; drives htw_dpath through ctl_t and reads sts_t
module htw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  htw_pkg::sts_t sts,
  output htw_pkg::ctl_t ctl
);
  import htw_pkg::*;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic   phase2, phase2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      mode   <= MODE_ADD;
      phase2 <= 1'b0;
    end else begin
      state  <= state_next;
      mode   <= mode_next;
      phase2 <= phase2_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    mode_next   = mode;
    phase2_next = phase2;
    ctl         = '0;
    case (state)
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          ctl.latch  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (cmd_t'(sts.cmd))
          CMD_ADD: begin
            mode_next = MODE_ADD;
            if (sts.delay_zero) begin
              ctl.emit   = 1'b1;
              ctl.kind   = sts.rep ? KIND_IGNORED : KIND_IMMEDIATE;
              state_next = ST_FLUSH;
            end else if (sts.pool_empty) begin
              ctl.emit   = 1'b1;
              ctl.kind   = KIND_FULL;
              state_next = ST_FLUSH;
            end else begin
              ctl.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          CMD_CANCEL: begin
            ctl.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
          CMD_TICK: begin
            ctl.b_load  = 1'b1;
            ctl.b_sel   = BSEL_FIRE;
            mode_next   = MODE_FIRE;
            phase2_next = 1'b0;
            state_next  = ST_TAKE_RD;
          end
          default: begin
            ctl.emit   = 1'b1;
            ctl.kind   = KIND_IGNORED;
            state_next = ST_FLUSH;
          end
        endcase
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (cmd_t'(sts.cmd) == CMD_ADD) begin
          ctl.scan_unreg = sts.rep;
          if (sts.scan_end) state_next = ST_ADD_WR;
        end else if (sts.scan_match) begin
          ctl.cancel_hit = 1'b1;
          ctl.emit       = 1'b1;
          ctl.emit_src   = SRC_CANCEL;
          state_next     = ST_FLUSH;
        end else if (sts.scan_end) begin
          ctl.emit   = 1'b1;
          ctl.kind   = KIND_IGNORED;
          state_next = ST_FLUSH;
        end
      end
      ST_ADD_WR: begin
        ctl.add_write = 1'b1;
        state_next    = ST_PLACE;
      end
      ST_PLACE: begin
        ctl.b_load = 1'b1;
        ctl.b_sel  = BSEL_PLACE;
        state_next = ST_PUSH_RD;
      end
      ST_PUSH_RD: begin
        ctl.push_rd = 1'b1;
        state_next  = ST_PUSH_WR;
      end
      ST_PUSH_WR: begin
        ctl.push_wr = 1'b1;
        case (mode)
          MODE_ADD:  state_next = ST_ADD_ACK;
          MODE_FIRE: state_next = ST_FIRE_RD;
          default:   state_next = ST_CASC_RD;
        endcase
      end
      ST_ADD_ACK: begin
        ctl.emit   = 1'b1;
        ctl.kind   = KIND_ADDED;
        state_next = ST_FLUSH;
      end
      ST_TAKE_RD: begin
        ctl.take_rd = 1'b1;
        state_next  = ST_TAKE_WR;
      end
      ST_TAKE_WR: begin
        ctl.take_wr = 1'b1;
        state_next  = (mode == MODE_FIRE) ? ST_FIRE_RD : ST_CASC_RD;
      end
      ST_FIRE_RD: begin
        if (sts.cur_empty) begin
          state_next = phase2 ? ST_FLUSH : ST_ADVANCE;
        end else begin
          ctl.walk_rd = 1'b1;
          state_next  = ST_FIRE_USE;
        end
      end
      ST_FIRE_USE: begin
        if (!sts.cur_live || sts.emit_ok) begin
          ctl.fire_use = 1'b1;
          ctl.emit     = sts.cur_live;
          ctl.emit_src = SRC_FIRE;
          state_next   = sts.rearm ? ST_PLACE : ST_FIRE_RD;
        end
      end
      ST_ADVANCE: begin
        ctl.adv    = 1'b1;
        state_next = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        ctl.b_load = 1'b1;
        state_next = ST_TAKE_RD;
        if (sts.casc_hit) begin
          ctl.b_sel = BSEL_CASC;
          mode_next = MODE_CASC;
        end else begin
          ctl.b_sel   = BSEL_FIRE;
          mode_next   = MODE_FIRE;
          phase2_next = 1'b1;
        end
      end
      ST_CASC_RD: begin
        if (sts.cur_empty) begin
          ctl.b_load  = 1'b1;
          ctl.b_sel   = BSEL_FIRE;
          mode_next   = MODE_FIRE;
          phase2_next = 1'b1;
          state_next  = ST_TAKE_RD;
        end else begin
          ctl.walk_rd = 1'b1;
          state_next  = ST_CASC_USE;
        end
      end
      ST_CASC_USE: begin
        ctl.casc_use = 1'b1;
        state_next   = ST_PLACE;
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.emit_ok) begin
          ctl.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/htw_dpath.sv
// htw_dpath: bucket and node memories, node flags, time and result staging
// depends on htw_pkg; sequenced by htw_ctrl
module htw_dpath #(
  parameter int NEAR_BITS   = 8,
  parameter int LEVEL_BITS  = 6,
  parameter int LEVEL_COUNT = 4,
  parameter int NODE_COUNT  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  htw_pkg::ctl_t                        ctl,
  output htw_pkg::sts_t                        sts,
  input  logic [htw_pkg::CMD_W-1:0]            req_cmd,
  input  logic [htw_pkg::HANDLE_W-1:0]         req_handle,
  input  logic signed [htw_pkg::SESSION_W-1:0] req_session,
  input  logic [htw_pkg::DELAY_W-1:0]          req_delay,
  input  logic                                 req_repeat,
  input  logic                                 rsp_ready,
  output logic                                 rsp_valid,
  output logic [htw_pkg::KIND_W-1:0]           rsp_kind,
  output logic [htw_pkg::HANDLE_W-1:0]         rsp_handle,
  output logic signed [htw_pkg::SESSION_W-1:0] rsp_session,
  output logic                                 rsp_last
);
  import htw_pkg::*;

  localparam int NEAR_SIZE  = 1 << NEAR_BITS;
  localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
  localparam int BUCKETS    = NEAR_SIZE + LEVEL_COUNT * LEVEL_SIZE;
  localparam int BW         = $clog2(BUCKETS);
  localparam int NW         = $clog2(NODE_COUNT);
  localparam logic [63:0] NMASK = 64'(NEAR_SIZE - 1);
  localparam logic [63:0] LMASK = 64'(LEVEL_SIZE - 1);

  logic [CMD_W-1:0]            in_cmd;
  logic [HANDLE_W-1:0]         in_handle;
  logic signed [SESSION_W-1:0] in_session;
  logic [DELAY_W-1:0]          in_delay;
  logic                        in_rep;

  logic [TICK_W-1:0] tick_now;
  logic [BW-1:0]     b_reg;
  logic [LINK_W-1:0] cur;
  logic [NW-1:0]     nd_reg;
  logic              nd_found;
  logic [TICK_W-1:0] exp_reg;
  logic [BW-1:0]     clr_k;
  logic              clr_done;
  logic [NW-1:0]     scan_k, scan_kd;
  logic              scan_kv, scan_all;

  logic [NODE_COUNT-1:0] live, registered, free_map;

  logic [LINK_W-1:0] head_mem [BUCKETS];
  logic [NW-1:0]     tail_mem [BUCKETS];
  logic [LINK_W-1:0] link_mem [NODE_COUNT];
  rec_t              rec_mem  [NODE_COUNT];
  logic [LINK_W-1:0] head_rd, link_rd;
  logic [NW-1:0]     tail_rd;
  rec_t              rec_rd;

  logic              head_we, link_we, rec_we, rec_re, scan_issue;
  logic [BW-1:0]     head_wa;
  logic [LINK_W-1:0] head_wd, link_wd;
  logic [NW-1:0]     link_wa, rec_wa, rec_ra, cur_i;
  rec_t              rec_wd;

  logic [BW-1:0]     place_b, casc_b, fire_b;
  logic              casc_hit;
  logic [TICK_W-1:0] exp_next;
  logic              cur_live, rearm, scan_match, scan_end, emit_ok;

  kind_t                       new_kind, pend_kind;
  logic [HANDLE_W-1:0]         new_handle, pend_handle;
  logic signed [SESSION_W-1:0] new_session, pend_session;
  logic                        pend_valid;

  assign cur_i      = cur[NW-1:0];
  assign cur_live   = live[cur_i];
  assign rearm      = cur_live && (rec_rd.period != '0);
  assign exp_next   = rec_rd.expire + TICK_W'(rec_rd.period);
  assign scan_match = scan_kv && registered[scan_kd] && (rec_rd.sess == in_session);
  assign scan_end   = scan_kv && (scan_kd == NW'(NODE_COUNT - 1));
  assign emit_ok    = !pend_valid || !rsp_valid || rsp_ready;
  assign fire_b     = BW'(tick_now & TICK_W'(NEAR_SIZE - 1));
  assign scan_issue = ctl.scan_step && !scan_all;

  // bucket for a node expiring at exp_reg
  always_comb begin
    logic [63:0] t, n;
    t = {32'd0, exp_reg};
    n = {32'd0, tick_now};
    place_b = BW'(NEAR_SIZE + (LEVEL_COUNT - 1) * LEVEL_SIZE)
            + BW'((t >> (NEAR_BITS + (LEVEL_COUNT - 1) * LEVEL_BITS)) & LMASK);
    for (int i = LEVEL_COUNT - 2; i >= 0; i--) begin
      if ((t >> (NEAR_BITS + (i + 1) * LEVEL_BITS)) ==
          (n >> (NEAR_BITS + (i + 1) * LEVEL_BITS))) begin
        place_b = BW'(NEAR_SIZE + i * LEVEL_SIZE)
                + BW'((t >> (NEAR_BITS + i * LEVEL_BITS)) & LMASK);
      end
    end
    if ((t >> NEAR_BITS) == (n >> NEAR_BITS)) place_b = BW'(t & NMASK);
  end

  // higher-level bucket to cascade after time advances
  always_comb begin
    logic [63:0] ct;
    logic        stop;
    ct       = {32'd0, tick_now};
    stop     = 1'b0;
    casc_hit = 1'b0;
    casc_b   = '0;
    for (int i = 0; i < LEVEL_COUNT; i++) begin
      if (!stop) begin
        if ((ct & ((64'd1 << (NEAR_BITS + i * LEVEL_BITS)) - 64'd1)) != 64'd0) begin
          stop = 1'b1;
        end else if (((ct >> (NEAR_BITS + i * LEVEL_BITS)) & LMASK) != 64'd0) begin
          stop     = 1'b1;
          casc_hit = 1'b1;
          casc_b   = BW'(NEAR_SIZE + i * LEVEL_SIZE)
                   + BW'((ct >> (NEAR_BITS + i * LEVEL_BITS)) & LMASK);
        end
      end
    end
    if (!stop) begin
      casc_hit = 1'b1;
      casc_b   = BW'(NEAR_SIZE + (LEVEL_COUNT - 1) * LEVEL_SIZE);
    end
  end

  // memory port muxing
  always_comb begin
    head_we = 1'b0;
    head_wa = b_reg;
    head_wd = EMPTY_MARK;
    if (ctl.clr_step && !clr_done) begin
      head_we = 1'b1;
      head_wa = clr_k;
    end else if (ctl.take_wr) begin
      head_we = 1'b1;
    end else if (ctl.push_wr && head_rd == EMPTY_MARK) begin
      head_we = 1'b1;
      head_wd = LINK_W'(nd_reg);
    end

    link_we = 1'b0;
    link_wa = nd_reg;
    link_wd = EMPTY_MARK;
    if (ctl.push_rd) begin
      link_we = 1'b1;
    end else if (ctl.push_wr && head_rd != EMPTY_MARK) begin
      link_we = 1'b1;
      link_wa = tail_rd;
      link_wd = LINK_W'(nd_reg);
    end

    rec_we = 1'b0;
    rec_wa = nd_reg;
    rec_wd = rec_rd;
    if (ctl.add_write) begin
      rec_we        = 1'b1;
      rec_wd.expire = tick_now + TICK_W'(in_delay);
      rec_wd.period = in_rep ? in_delay : '0;
      rec_wd.dest   = in_handle;
      rec_wd.sess   = in_session;
    end else if (ctl.fire_use && rearm) begin
      rec_we        = 1'b1;
      rec_wa        = cur_i;
      rec_wd.expire = exp_next;
    end

    rec_re = scan_issue || ctl.walk_rd;
    rec_ra = scan_issue ? scan_k : cur_i;
  end

  always_ff @(posedge clk) begin
    if (ctl.take_rd || ctl.push_rd) begin
      head_rd <= head_mem[b_reg];
      tail_rd <= tail_mem[b_reg];
    end
    if (head_we) head_mem[head_wa] <= head_wd;
    if (ctl.push_wr) tail_mem[b_reg] <= nd_reg;
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_rd) link_rd <= link_mem[cur_i];
    if (link_we) link_mem[link_wa] <= link_wd;
  end

  always_ff @(posedge clk) begin
    if (rec_re) rec_rd <= rec_mem[rec_ra];
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      in_cmd     <= req_cmd;
      in_handle  <= req_handle;
      in_session <= req_session;
      in_delay   <= req_delay;
      in_rep     <= req_repeat;
    end
    if (ctl.b_load) begin
      case (ctl.b_sel)
        BSEL_FIRE:  b_reg <= fire_b;
        BSEL_CASC:  b_reg <= casc_b;
        default:    b_reg <= place_b;
      endcase
    end
    if (ctl.take_wr) cur <= head_rd;
    if (ctl.fire_use || ctl.casc_use) begin
      cur    <= link_rd;
      nd_reg <= cur_i;
    end
    if (ctl.casc_use) exp_reg <= rec_rd.expire;
    if (ctl.fire_use && rearm) exp_reg <= exp_next;
    if (ctl.add_write) exp_reg <= tick_now + TICK_W'(in_delay);
    if (ctl.scan_step && scan_kv && free_map[scan_kd] && !nd_found) nd_reg <= scan_kd;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now   <= '0;
      clr_k      <= '0;
      clr_done   <= 1'b0;
      scan_k     <= '0;
      scan_kd    <= '0;
      scan_kv    <= 1'b0;
      scan_all   <= 1'b0;
      nd_found   <= 1'b0;
      live       <= '0;
      registered <= '0;
      free_map   <= '1;
    end else begin
      if (ctl.adv) tick_now <= tick_now + 1'b1;
      if (ctl.clr_step && !clr_done) begin
        if (clr_k == BW'(BUCKETS - 1)) clr_done <= 1'b1;
        else clr_k <= clr_k + 1'b1;
      end
      if (ctl.scan_start) begin
        scan_k   <= '0;
        scan_kv  <= 1'b0;
        scan_all <= 1'b0;
        nd_found <= 1'b0;
      end else if (ctl.scan_step) begin
        scan_kv <= scan_issue;
        if (scan_issue) begin
          scan_kd <= scan_k;
          if (scan_k == NW'(NODE_COUNT - 1)) scan_all <= 1'b1;
          else scan_k <= scan_k + 1'b1;
        end
        if (scan_kv && free_map[scan_kd]) nd_found <= 1'b1;
      end
      if (ctl.scan_unreg && scan_match) registered[scan_kd] <= 1'b0;
      if (ctl.cancel_hit) begin
        live[scan_kd]       <= 1'b0;
        registered[scan_kd] <= 1'b0;
      end
      if (ctl.add_write) begin
        free_map[nd_reg]   <= 1'b0;
        live[nd_reg]       <= 1'b1;
        registered[nd_reg] <= in_rep;
      end
      if (ctl.fire_use && !rearm) begin
        live[cur_i]       <= 1'b0;
        registered[cur_i] <= 1'b0;
        free_map[cur_i]   <= 1'b1;
      end
    end
  end

  // result staging: pending result plus output register
  always_comb begin
    new_kind    = ctl.kind;
    new_handle  = in_handle;
    new_session = in_session;
    case (ctl.emit_src)
      SRC_FIRE: begin
        new_kind    = (rec_rd.period != '0) ? KIND_REPEAT : KIND_ONESHOT;
        new_handle  = rec_rd.dest;
        new_session = rec_rd.sess;
      end
      SRC_CANCEL: begin
        new_kind    = KIND_CANCEL;
        new_handle  = rec_rd.dest;
        new_session = rec_rd.sess;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if ((ctl.emit && pend_valid) || ctl.flush) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      if (ctl.emit) pend_valid <= 1'b1;
      else if (ctl.flush) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctl.emit && pend_valid) || ctl.flush) begin
      rsp_kind    <= pend_kind;
      rsp_handle  <= pend_handle;
      rsp_session <= pend_session;
      rsp_last    <= ctl.flush;
    end
    if (ctl.emit) begin
      pend_kind    <= new_kind;
      pend_handle  <= new_handle;
      pend_session <= new_session;
    end
  end

  always_comb begin
    sts            = '0;
    sts.clr_done   = clr_done;
    sts.cmd        = in_cmd;
    sts.delay_zero = (in_delay == '0);
    sts.rep        = in_rep;
    sts.pool_empty = (free_map == '0);
    sts.scan_match = scan_match;
    sts.scan_end   = scan_end;
    sts.cur_empty  = (cur >= LINK_W'(NODE_COUNT));
    sts.cur_live   = cur_live;
    sts.rearm      = rearm;
    sts.casc_hit   = casc_hit;
    sts.emit_ok    = emit_ok;
    sts.pend_valid = pend_valid;
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> emit_ok) else $error("result staged over a held result");
  a_flush_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |-> (emit_ok && pend_valid)) else $error("flush without free slot");
  a_live_not_free: assert property (@(posedge clk) disable iff (rst)
    (live & free_map) == '0) else $error("live node in free pool");
  a_reg_is_live: assert property (@(posedge clk) disable iff (rst)
    (registered & ~live) == '0) else $error("registered node not live");

endmodule

FILE: sv/hierarchical_timer_wheel_unit.sv
// hierarchical_timer_wheel_unit: top level of the hierarchical timer wheel
// depends on htw_pkg, htw_req_if, htw_rsp_if, htw_ctrl and htw_dpath
//
// req carries one command per transfer: add (handle, session, delay,
// repeat_req), cancel by session, or tick. rsp returns the results of each
// command in order, with last set on the final one. add and cancel always
// give one result; a tick gives one per live timer that expires, possibly none.
// Commands are taken one at a time: req.ready is high only while the block
// is idle, but a result still waiting in the output register does not hold
// off the next command.
// An add with a nonzero delay and a free node, and each cancel, run a session
// scan over the node record memory, one node per cycle. A tick fires the
// current near bucket, advances time, cascades a higher-level bucket when one
// is due and fires the new current bucket; re-armed and cascaded nodes are
// pushed into a bucket, and each bucket access goes through the single read
// port of the bucket memories. After reset the 2^NEAR_BITS + LEVEL_COUNT *
// 2^LEVEL_BITS bucket heads (512 by default) are swept to empty, one per
// cycle, before the first command is taken. When rsp stalls, the walk stops
// at the next expiring timer until the held result is transferred.
module hierarchical_timer_wheel_unit #(
  parameter int NEAR_BITS   = 8,
  parameter int LEVEL_BITS  = 6,
  parameter int LEVEL_COUNT = 4,
  parameter int NODE_COUNT  = 64
) (
  input logic      clk,
  input logic      rst,
  htw_req_if.sink  req,
  htw_rsp_if.source rsp
);
  import htw_pkg::*;

  ctl_t ctl;
  sts_t sts;

  htw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  htw_dpath #(
    .NEAR_BITS   (NEAR_BITS),
    .LEVEL_BITS  (LEVEL_BITS),
    .LEVEL_COUNT (LEVEL_COUNT),
    .NODE_COUNT  (NODE_COUNT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .req_cmd     (req.cmd),
    .req_handle  (req.handle),
    .req_session (req.session),
    .req_delay   (req.delay),
    .req_repeat  (req.repeat_req),
    .rsp_ready   (rsp.ready),
    .rsp_valid   (rsp.valid),
    .rsp_kind    (rsp.kind),
    .rsp_handle  (rsp.handle_out),
    .rsp_session (rsp.session_out),
    .rsp_last    (rsp.last)
  );

endmodule

FILE: tb/htw_scoreboard.sv
// htw_scoreboard: watches the command and result channels of the timer wheel,
// predicts each command's results and compares them transfer by transfer
// depends on htw_pkg, htw_req_if and htw_rsp_if
module htw_scoreboard (
  input  logic clk,
  input  logic rst,
  htw_req_if   req,
  htw_rsp_if   rsp,
  output int   fails,
  output int   pending
);
  import htw_pkg::*;

  localparam int NEAR_W   = 8;
  localparam int LVL_W    = 6;
  localparam int LVLS     = 4;
  localparam int NODES    = 64;
  localparam int NEAR_N   = 1 << NEAR_W;
  localparam int LVL_N    = 1 << LVL_W;
  localparam int N_BUCKET = NEAR_N + LVLS * LVL_N;

  typedef struct {
    kind_t       kind;
    logic [31:0] handle;
    logic [31:0] session;
    logic        last;
  } timer_event_t;

  timer_event_t events_due[$];

  logic [31:0] now_tick;
  logic [6:0]  head_of [N_BUCKET];
  logic [6:0]  tail_of [N_BUCKET];
  logic [31:0] expire_at [NODES];
  logic [30:0] period_of [NODES];
  logic [31:0] dest_of [NODES];
  logic [31:0] sess_of [NODES];
  logic [6:0]  next_of [NODES];
  logic        live [NODES];
  logic        owner [NODES];
  logic [63:0] free_nodes;

  assign pending = events_due.size();

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void post(input kind_t k, input logic [31:0] h, input logic [31:0] s);
    timer_event_t e;
    e.kind = k;
    e.handle = h;
    e.session = s;
    e.last = 1'b0;
    events_due.push_back(e);
  endfunction

  function automatic void push_bucket(input int b, input int nd);
    if (head_of[b] == EMPTY_MARK) head_of[b] = 7'(nd);
    else next_of[tail_of[b]] = 7'(nd);
    tail_of[b] = 7'(nd);
    next_of[nd] = EMPTY_MARK;
  endfunction

  function automatic int take_bucket(input int b);
    int h;
    h = head_of[b];
    head_of[b] = EMPTY_MARK;
    return h;
  endfunction

  function automatic void place_timer(input int nd);
    logic [31:0] t;
    int i, sh;
    t = expire_at[nd];
    i = 0;
    if ((t >> NEAR_W) == (now_tick >> NEAR_W)) begin
      push_bucket(int'(t[NEAR_W-1:0]), nd);
      return;
    end
    while (i < LVLS - 1) begin
      sh = NEAR_W + (i + 1) * LVL_W;
      if ((t >> sh) == (now_tick >> sh)) break;
      i++;
    end
    push_bucket(NEAR_N + i * LVL_N + int'((t >> (NEAR_W + i * LVL_W)) & (LVL_N - 1)), nd);
  endfunction

  function automatic void cascade_slot(input int level, input int slot);
    int cur, nx, guard;
    cur = take_bucket(NEAR_N + level * LVL_N + slot);
    guard = 0;
    while (cur < NODES && guard < NODES) begin
      nx = next_of[cur];
      place_timer(cur);
      cur = nx;
      guard++;
    end
  endfunction

  function automatic void fire_current();
    int cur, nx, guard;
    cur = take_bucket(int'(now_tick[NEAR_W-1:0]));
    guard = 0;
    while (cur < NODES && guard < NODES) begin
      nx = next_of[cur];
      if (live[cur])
        post(period_of[cur] != 0 ? KIND_REPEAT : KIND_ONESHOT, dest_of[cur], sess_of[cur]);
      if (period_of[cur] != 0 && live[cur]) begin
        expire_at[cur] = expire_at[cur] + 32'(period_of[cur]);
        place_timer(cur);
      end else begin
        live[cur] = 1'b0;
        owner[cur] = 1'b0;
        free_nodes[cur] = 1'b1;
      end
      cur = nx;
      guard++;
    end
  endfunction

  function automatic void advance_time();
    logic [63:0] ct;
    int sh, idx;
    now_tick = now_tick + 1;
    ct = 64'(now_tick);
    for (int i = 0; i < LVLS; i++) begin
      sh = NEAR_W + i * LVL_W;
      if ((ct & ((64'd1 << sh) - 1)) != 0) return;
      idx = int'((ct >> sh) & (LVL_N - 1));
      if (idx != 0) begin
        cascade_slot(i, idx);
        return;
      end
    end
    cascade_slot(LVLS - 1, 0);
  endfunction

  function automatic void add_timer(input logic [31:0] h, input logic [31:0] s,
                                    input logic [30:0] d, input logic rep);
    int nd;
    if (d == 0) begin
      post(rep ? KIND_IGNORED : KIND_IMMEDIATE, h, s);
      return;
    end
    if (free_nodes == 0) begin
      post(KIND_FULL, h, s);
      return;
    end
    nd = 0;
    while (!free_nodes[nd]) nd++;
    free_nodes[nd] = 1'b0;
    dest_of[nd] = h;
    sess_of[nd] = s;
    period_of[nd] = rep ? d : '0;
    live[nd] = 1'b1;
    owner[nd] = 1'b0;
    expire_at[nd] = now_tick + 32'(d);
    if (rep) begin
      for (int k = 0; k < NODES; k++)
        if (owner[k] && sess_of[k] == s) owner[k] = 1'b0;
      owner[nd] = 1'b1;
    end
    place_timer(nd);
    post(KIND_ADDED, h, s);
  endfunction

  function automatic void cancel_timer(input logic [31:0] h, input logic [31:0] s);
    for (int k = 0; k < NODES; k++) begin
      if (owner[k] && sess_of[k] == s) begin
        live[k] = 1'b0;
        owner[k] = 1'b0;
        post(KIND_CANCEL, dest_of[k], sess_of[k]);
        return;
      end
    end
    post(KIND_IGNORED, h, s);
  endfunction

  function automatic void predict_command(input logic [1:0] c, input logic [31:0] h,
                                          input logic [31:0] s, input logic [30:0] d,
                                          input logic rep);
    int before_n;
    before_n = events_due.size();
    case (c)
      CMD_ADD:    add_timer(h, s, d, rep);
      CMD_CANCEL: cancel_timer(h, s);
      CMD_TICK: begin
        fire_current();
        advance_time();
        fire_current();
      end
      default:    post(KIND_IGNORED, h, s);
    endcase
    if (events_due.size() > before_n) events_due[events_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    timer_event_t e;
    if (rst) begin
      now_tick = 0;
      free_nodes = '1;
      for (int b = 0; b < N_BUCKET; b++) begin
        head_of[b] = EMPTY_MARK;
        tail_of[b] = '0;
      end
      for (int k = 0; k < NODES; k++) begin
        live[k] = 1'b0;
        owner[k] = 1'b0;
        next_of[k] = EMPTY_MARK;
      end
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (events_due.size() == 0) begin
          report($sformatf("unexpected result kind %0d handle %h", rsp.kind, rsp.handle_out));
        end else begin
          e = events_due.pop_front();
          if (rsp.kind != e.kind)
            report($sformatf("kind %0d, expected %0d", rsp.kind, e.kind));
          if (rsp.handle_out != e.handle)
            report($sformatf("handle %h, expected %h", rsp.handle_out, e.handle));
          if (rsp.session_out != e.session)
            report($sformatf("session %h, expected %h", rsp.session_out, e.session));
          if (rsp.last != e.last)
            report($sformatf("last %0d, expected %0d", rsp.last, e.last));
        end
      end
      if (req.valid && req.ready)
        predict_command(req.cmd, req.handle, req.session, req.delay, req.repeat_req);
    end
  end

  initial fails = 0;
endmodule

FILE: tb/hierarchical_timer_wheel_unit_tb.sv
// hierarchical_timer_wheel_unit_tb: drives commands in bursts with random gaps,
// stalls the result side and gives the verdict from the scoreboard's count
// depends on htw_pkg, htw_req_if, htw_rsp_if, htw_scoreboard and the block
module hierarchical_timer_wheel_unit_tb;
  import htw_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_CMDS = 340;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   pending;
  int   idle_cycles;
  int   burst_left;
  int   ready_mode;
  int   mode_left;

  htw_req_if req ();
  htw_rsp_if rsp ();

  hierarchical_timer_wheel_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));
  htw_scoreboard scoreboard (.clk(clk), .rst(rst), .req(req), .rsp(rsp),
                             .fails(fails), .pending(pending));

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= 1'($urandom_range(0, 1));
      default: rsp.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL hierarchical_timer_wheel_unit");
      $finish;
    end
  end

  task automatic send(input logic [1:0] c, input logic [31:0] h, input logic [31:0] s,
                      input logic [30:0] d, input logic rep);
    req.valid = 1'b1;
    req.cmd = c;
    req.handle = h;
    req.session = s;
    req.delay = d;
    req.repeat_req = rep;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_session();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [30:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 75) return 31'($urandom_range(1, 40));
    if (r < 92) return 31'($urandom_range(41, 600));
    return 31'($urandom);
  endfunction

  initial begin
    int r;
    req.valid = 1'b0;
    req.cmd = CMD_TICK;
    req.handle = '0;
    req.session = '0;
    req.delay = '0;
    req.repeat_req = 1'b0;
    rsp.ready = 1'b0;
    idle_cycles = 0;
    burst_left = 0;
    mode_left = 0;
    ready_mode = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(CMD_ADD, 32'hffff_ffff, 32'h8000_0000, '0, 1'b0);
    send(CMD_ADD, 32'h1234_5678, 32'h7fff_ffff, '0, 1'b1);
    send(CMD_ADD, 32'h0, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0);
    send(CMD_ADD, 32'ha5a5_a5a5, 32'd7, 31'd1, 1'b1);
    send(CMD_ADD, 32'h5a5a_5a5a, 32'd7, 31'd3, 1'b1);
    send(CMD_CANCEL, 32'h1, 32'd7, '0, 1'b0);
    send(CMD_CANCEL, 32'h2, 32'd7, '0, 1'b0);
    send(CMD_CANCEL, 32'h3, 32'd12345, '0, 1'b0);
    send(2'd3, 32'hdead_beef, 32'h8000_0000, 31'h7fff_ffff, 1'b1);
    send(CMD_ADD, 32'h11, 32'd1, 31'd255, 1'b0);
    send(CMD_ADD, 32'h22, 32'd1, 31'd256, 1'b0);
    send(CMD_ADD, 32'h33, 32'd1, 31'd300, 1'b0);
    send(CMD_ADD, 32'h44, 32'd2, 31'd2, 1'b1);
    repeat (6) send(CMD_TICK, $urandom, $urandom, 31'($urandom), 1'b0);
    send(CMD_CANCEL, 32'h4, 32'd2, '0, 1'b0);
    send(CMD_TICK, 32'h0, 32'h0, '0, 1'b0);
    drain();

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS / 2) begin
        drain();
        repeat (70) send(CMD_ADD, $urandom, pick_session(), 31'($urandom_range(1, 30)),
                         $urandom_range(0, 5) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 45)
        send(CMD_ADD, $urandom, pick_session(), pick_delay(), $urandom_range(0, 9) < 3);
      else if (r < 57)
        send(CMD_CANCEL, $urandom, pick_session(), 31'($urandom),
             1'($urandom_range(0, 1)));
      else if (r < 97)
        send(CMD_TICK, $urandom, $urandom, 31'($urandom), 1'($urandom_range(0, 1)));
      else
        send(2'd3, $urandom, $urandom, 31'($urandom), 1'($urandom_range(0, 1)));
    end
    drain();

    if (fails == 0) $display("PASS hierarchical_timer_wheel_unit");
    else $display("FAIL hierarchical_timer_wheel_unit");
    $finish;
  end
endmodule
